@@ hdl/fcpa_pkg.sv @@
// shared types, constants and helpers of the fixed chunk pool allocator
package fcpa_pkg;

    localparam int MaxChunks = 256;
    localparam int AddrW     = $clog2(MaxChunks);
    localparam int CntW      = AddrW + 1;

    localparam int KindW     = 2;
    localparam int ReqW      = 17;
    localparam int OffW      = 24;
    localparam int BytesW    = 25;
    localparam int ShiftW    = 5;
    localparam int CountW    = 9;
    localparam int CfgDataW  = 9;
    localparam int CfgIdxW   = 1;

    localparam logic [ShiftW-1:0] ShiftMin   = ShiftW'(3);
    localparam logic [ShiftW-1:0] ShiftMax   = ShiftW'(16);
    localparam logic [ShiftW-1:0] ShiftReset = ShiftW'(3);
    localparam logic [CountW-1:0] CountReset = CountW'(256);

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_SIZE   = 3'd2,
        ST_OFFSET = 3'd3,
        ST_EMPTY  = 3'd4
    } t_status;

    typedef enum logic [KindW-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_RESET = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CHUNK_SHIFT = 1'd0,
        REG_CHUNK_COUNT = 1'd1
    } t_reg_idx;

    // item after the decision stage, waiting for the stack read
    typedef struct packed {
        logic             valid;
        t_status          status;
        logic             alloc_ok;
        logic             from_stack;
        logic [AddrW-1:0] idx;
        logic [CntW-1:0]  used;
        logic [CntW-1:0]  peak;
    } t_stage;

    function automatic logic [ShiftW-1:0] eff_shift(input logic [ShiftW-1:0] s);
        logic [ShiftW-1:0] r;
        if (s < ShiftMin) begin
            r = ShiftMin;
        end else if (s > ShiftMax) begin
            r = ShiftMax;
        end else begin
            r = s;
        end
        return r;
    endfunction

    function automatic logic [CntW-1:0] eff_count(input logic [CountW-1:0] c);
        logic [CntW-1:0] r;
        if (c == '0) begin
            r = CntW'(1);
        end else if (32'(c) > MaxChunks) begin
            r = CntW'(MaxChunks);
        end else begin
            r = CntW'(c);
        end
        return r;
    endfunction

endpackage

@@ hdl/fcpa_ram.sv @@
// generic single write port ram with registered read
module fcpa_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/fcpa_core.sv @@
// configuration registers, pool counters and the per-request decision
module fcpa_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic [fcpa_pkg::KindW-1:0]     i_kind,
    input  logic [fcpa_pkg::ReqW-1:0]      i_request_bytes,
    input  logic [fcpa_pkg::OffW-1:0]      i_free_offset,
    input  logic                           i_cfg_we,
    input  logic [fcpa_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [fcpa_pkg::CfgDataW-1:0]  i_cfg_data,
    output logic                           o_ram_we,
    output logic [fcpa_pkg::AddrW-1:0]     o_ram_waddr,
    output logic [fcpa_pkg::AddrW-1:0]     o_ram_wdata,
    output logic [fcpa_pkg::AddrW-1:0]     o_ram_raddr,
    output logic [fcpa_pkg::ShiftW-1:0]    o_shift,
    output fcpa_pkg::t_stage               o_stage
);
    import fcpa_pkg::*;

    logic [ShiftW-1:0] r_chunk_shift, n_chunk_shift;
    logic [CountW-1:0] r_chunk_count, n_chunk_count;
    logic [CntW-1:0]   r_depth, n_depth;
    logic [CntW-1:0]   r_untouched, n_untouched;
    logic [CntW-1:0]   r_used, n_used;
    logic [CntW-1:0]   r_peak, n_peak;
    t_stage            r_stage, n_stage;

    logic [ShiftW-1:0] shift_eff;
    logic [CntW-1:0]   count_eff;
    logic [ReqW-1:0]   csize;
    logic [OffW-1:0]   off_mask;
    logic [OffW-1:0]   free_idx;
    logic              size_ok;
    logic              off_ok;
    logic [CntW-1:0]   used_inc;

    assign shift_eff = eff_shift(r_chunk_shift);
    assign count_eff = eff_count(r_chunk_count);
    assign csize     = ReqW'(1) << shift_eff;
    assign off_mask  = OffW'(csize - ReqW'(1));
    assign free_idx  = i_free_offset >> shift_eff;
    assign size_ok   = (i_request_bytes == csize);
    assign off_ok    = ((i_free_offset & off_mask) == '0) && (free_idx < OffW'(count_eff));
    assign used_inc  = r_used + CntW'(1);

    always_comb begin
        n_chunk_shift = r_chunk_shift;
        n_chunk_count = r_chunk_count;
        n_depth       = r_depth;
        n_untouched   = r_untouched;
        n_used        = r_used;
        n_peak        = r_peak;
        n_stage       = '0;
        n_stage.status = ST_OK;
        o_ram_we      = 1'b0;
        o_ram_waddr   = r_depth[AddrW-1:0];
        o_ram_wdata   = free_idx[AddrW-1:0];
        o_ram_raddr   = AddrW'(r_depth - CntW'(1));

        if (i_cfg_we) begin
            if (i_cfg_index == REG_CHUNK_SHIFT) begin
                n_chunk_shift = i_cfg_data[ShiftW-1:0];
                n_untouched   = count_eff;
            end else begin
                n_chunk_count = i_cfg_data[CountW-1:0];
                n_untouched   = eff_count(i_cfg_data[CountW-1:0]);
            end
            n_depth = '0;
            n_used  = '0;
            n_peak  = '0;
        end else if (i_take) begin
            n_stage.valid = 1'b1;
            case (t_kind'(i_kind))
                KIND_ALLOC: begin
                    if (!size_ok) begin
                        n_stage.status = ST_SIZE;
                    end else if (r_depth == '0 && r_untouched == '0) begin
                        n_stage.status = ST_FULL;
                    end else begin
                        n_stage.alloc_ok = 1'b1;
                        if (r_depth != '0) begin
                            // index comes out of the ram next cycle
                            n_stage.from_stack = 1'b1;
                            n_depth = r_depth - CntW'(1);
                        end else begin
                            n_untouched = r_untouched - CntW'(1);
                            n_stage.idx = AddrW'(n_untouched);
                        end
                        n_used = used_inc;
                        if (used_inc > r_peak) begin
                            n_peak = used_inc;
                        end
                    end
                end
                KIND_FREE: begin
                    if (!off_ok) begin
                        n_stage.status = ST_OFFSET;
                    end else if (r_used == '0) begin
                        n_stage.status = ST_EMPTY;
                    end else begin
                        if (32'(r_depth) < MaxChunks) begin
                            o_ram_we = 1'b1;
                            n_depth  = r_depth + CntW'(1);
                        end
                        n_used = r_used - CntW'(1);
                    end
                end
                KIND_RESET: begin
                    n_depth     = '0;
                    n_untouched = count_eff;
                    n_used      = '0;
                    n_peak      = '0;
                end
                default: begin
                end
            endcase
            n_stage.used = n_used;
            n_stage.peak = n_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_shift <= ShiftReset;
            r_chunk_count <= CountReset;
            r_depth       <= '0;
            r_untouched   <= eff_count(CountReset);
            r_used        <= '0;
            r_peak        <= '0;
            r_stage       <= '0;
        end else begin
            r_chunk_shift <= n_chunk_shift;
            r_chunk_count <= n_chunk_count;
            r_depth       <= n_depth;
            r_untouched   <= n_untouched;
            r_used        <= n_used;
            r_peak        <= n_peak;
            r_stage       <= n_stage;
        end
    end

    assign o_shift = shift_eff;
    assign o_stage = r_stage;

endmodule

@@ hdl/fcpa_result.sv @@
// result register: picks the chunk index and scales counts to bytes
module fcpa_result (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fcpa_pkg::t_stage             i_stage,
    input  logic [fcpa_pkg::AddrW-1:0]   i_stack_idx,
    input  logic [fcpa_pkg::ShiftW-1:0]  i_shift,
    output logic                         o_valid,
    output logic [2:0]                   o_status,
    output logic [fcpa_pkg::OffW-1:0]    o_chunk_offset,
    output logic [fcpa_pkg::BytesW-1:0]  o_used_bytes,
    output logic [fcpa_pkg::BytesW-1:0]  o_peak_bytes
);
    import fcpa_pkg::*;

    logic              r_valid;
    logic [2:0]        r_status;
    logic [OffW-1:0]   r_chunk_offset, n_chunk_offset;
    logic [BytesW-1:0] r_used_bytes, n_used_bytes;
    logic [BytesW-1:0] r_peak_bytes, n_peak_bytes;
    logic [AddrW-1:0]  idx;

    assign idx = i_stage.from_stack ? i_stack_idx : i_stage.idx;

    always_comb begin
        n_chunk_offset = '0;
        if (i_stage.alloc_ok) begin
            n_chunk_offset = OffW'(idx) << i_shift;
        end
        n_used_bytes = BytesW'(i_stage.used) << i_shift;
        n_peak_bytes = BytesW'(i_stage.peak) << i_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
        r_status       <= i_stage.status;
        r_chunk_offset <= n_chunk_offset;
        r_used_bytes   <= n_used_bytes;
        r_peak_bytes   <= n_peak_bytes;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_chunk_offset = r_chunk_offset;
    assign o_used_bytes   = r_used_bytes;
    assign o_peak_bytes   = r_peak_bytes;

endmodule

@@ hdl/fixed_chunk_pool_allocator.sv @@
// top level of the fixed chunk pool allocator
//
// Takes one request per cycle (allocate, free or pool reset) and returns one
// result item per request not issued together with a config write, strobed
// by o_valid for a single cycle; the receiver cannot stall, and busy stays
// low, so a request may be issued on every cycle. A result passes through the
// decision stage, where counters update and the freed-index ram is read or
// written, and the result stage, which takes the ram's registered read data
// and scales chunk counts to bytes. Chunks come out highest index first after
// a pool reset; freed chunks are reused newest first. Writing either config
// register resets the pool. Errors are reported in o_status and leave the
// pool unchanged. No clearing pass is needed after reset.
module fixed_chunk_pool_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [fcpa_pkg::KindW-1:0]     i_kind,
    input  logic [fcpa_pkg::ReqW-1:0]      i_request_bytes,
    input  logic [fcpa_pkg::OffW-1:0]      i_free_offset,
    input  logic                           i_cfg_we,
    input  logic [fcpa_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [fcpa_pkg::CfgDataW-1:0]  i_cfg_data,
    output logic                           o_valid,
    output logic [2:0]                     o_status,
    output logic [fcpa_pkg::OffW-1:0]      o_chunk_offset,
    output logic [fcpa_pkg::BytesW-1:0]    o_used_bytes,
    output logic [fcpa_pkg::BytesW-1:0]    o_peak_bytes
);
    import fcpa_pkg::*;

    logic             take;
    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    logic [AddrW-1:0] ram_wdata;
    logic [AddrW-1:0] ram_raddr;
    logic [AddrW-1:0] ram_rdata;
    logic [ShiftW-1:0] shift;
    t_stage           stage;

    // every request is taken as it arrives
    assign busy = 1'b0;
    assign take = start & ~busy;

    // decision stage: counters, config and freed-stack pointer
    fcpa_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_kind          (i_kind),
        .i_request_bytes (i_request_bytes),
        .i_free_offset   (i_free_offset),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_raddr     (ram_raddr),
        .o_shift         (shift),
        .o_stage         (stage)
    );

    // stack of freed chunk indices, only entries below the depth are used
    fcpa_ram #(
        .Width (AddrW),
        .Depth (MaxChunks)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // result stage
    fcpa_result u_result (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stage        (stage),
        .i_stack_idx    (ram_rdata),
        .i_shift        (shift),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_chunk_offset (o_chunk_offset),
        .o_used_bytes   (o_used_bytes),
        .o_peak_bytes   (o_peak_bytes)
    );

endmodule

@@ hdl/fcpa_checker.sv @@
// port-level checks of the allocator, bound to the top level
module fcpa_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           i_cfg_we,
    input  logic                           o_valid,
    input  logic [2:0]                     o_status,
    input  logic [fcpa_pkg::OffW-1:0]      o_chunk_offset,
    input  logic [fcpa_pkg::BytesW-1:0]    o_used_bytes,
    input  logic [fcpa_pkg::BytesW-1:0]    o_peak_bytes
);
    import fcpa_pkg::*;

    // every item accepted outside a config write gives a result after the decision and result stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_we) |=> ##1 o_valid)
        else $error("accepted item produced no result");

    // no result without an accepted item that went through the decision stage
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, 2)) |-> $past(start && !busy, 2))
        else $error("result without an accepted item");

    // failed results carry no offset
    a_err_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_chunk_offset == '0))
        else $error("error result with nonzero offset");

    // usage never exceeds the peak
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_used_bytes <= o_peak_bytes))
        else $error("used bytes above peak");

endmodule

bind fixed_chunk_pool_allocator fcpa_checker u_fcpa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cfg_we       (i_cfg_we),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_chunk_offset (o_chunk_offset),
    .o_used_bytes   (o_used_bytes),
    .o_peak_bytes   (o_peak_bytes)
);

@@ sim/tb_fixed_chunk_pool_allocator.sv @@
// testbench of the fixed chunk pool allocator: directed and random requests checked per field
module tb_fixed_chunk_pool_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import fcpa_pkg::*;

    // one result item as the block should report it
    typedef struct {
        t_status             status;
        logic [OffW-1:0]     offset;
        logic [BytesW-1:0]   used;
        logic [BytesW-1:0]   peak;
    } t_pool_answer;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [KindW-1:0]      i_kind = '0;
    logic [ReqW-1:0]       i_request_bytes = '0;
    logic [OffW-1:0]       i_free_offset = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]    i_cfg_index = '0;
    logic [CfgDataW-1:0]   i_cfg_data = '0;
    logic                  o_valid;
    logic [2:0]            o_status;
    logic [OffW-1:0]       o_chunk_offset;
    logic [BytesW-1:0]     o_used_bytes;
    logic [BytesW-1:0]     o_peak_bytes;

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    fixed_chunk_pool_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_request_bytes (i_request_bytes),
        .i_free_offset   (i_free_offset),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_chunk_offset  (o_chunk_offset),
        .o_used_bytes    (o_used_bytes),
        .o_peak_bytes    (o_peak_bytes)
    );

    // ------------------------------------------------------------------
    // pool mirror: register copies and the allocator state
    // ------------------------------------------------------------------
    logic [ShiftW-1:0]  cfg_shift;
    logic [CountW-1:0]  cfg_count;
    logic [AddrW-1:0]   freed_idx [MaxChunks];   // freed chunk indices, newest on top
    int unsigned        freed_top;               // entries on the freed stack
    int unsigned        fresh_left;              // untouched chunks, handed out top down
    int unsigned        in_use;
    int unsigned        high_water;

    t_pool_answer       answers_due [$];         // results owed by the block, oldest first
    logic [OffW-1:0]    held [$];                // offsets currently handed out (stimulus hint)

    int gap_style;                               // 0 mostly back to back, 1 mostly short, 2 full
    int mismatches;
    int items_sent;
    int alloc_count;
    int free_count;
    int cfg_writes;
    int status_seen [8];

    // register values outside the legal range are clamped
    function automatic int unsigned live_shift();
        if (cfg_shift < 3) return 3;
        if (cfg_shift > 16) return 16;
        return int'(cfg_shift);
    endfunction

    function automatic int unsigned live_count();
        if (cfg_count == 0) return 1;
        if (int'(cfg_count) > MaxChunks) return MaxChunks;
        return int'(cfg_count);
    endfunction

    // every chunk free again, chunks come out from the top index down
    function automatic void clear_pool();
        freed_top  = 0;
        fresh_left = live_count();
        in_use     = 0;
        high_water = 0;
    endfunction

    // outcome of one request, updating the mirrored pool state
    function automatic t_pool_answer pool_answer(input t_kind k, input logic [ReqW-1:0] req,
                                                 input logic [OffW-1:0] offs);
        t_pool_answer r;
        int unsigned  sh;
        int unsigned  cnt;
        int unsigned  csize;
        int unsigned  idx;
        sh       = live_shift();
        cnt      = live_count();
        csize    = 32'd1 << sh;
        r.status = ST_OK;
        r.offset = '0;
        case (k)
            KIND_ALLOC: begin
                // wrong size wins over pool full
                if (32'(req) != csize) begin
                    r.status = ST_SIZE;
                end else if (freed_top == 0 && fresh_left == 0) begin
                    r.status = ST_FULL;
                end else begin
                    if (freed_top > 0) begin
                        freed_top--;
                        idx = freed_idx[freed_top];
                    end else begin
                        fresh_left--;
                        idx = fresh_left;
                    end
                    r.offset = OffW'(idx << sh);
                    in_use++;
                    if (in_use > high_water) high_water = in_use;
                end
            end
            KIND_FREE: begin
                // bad offset wins over nothing allocated; double frees go through
                idx = 32'(offs) >> sh;
                if ((32'(offs) & (csize - 1)) != 0 || idx >= cnt) begin
                    r.status = ST_OFFSET;
                end else if (in_use == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (freed_top < MaxChunks) begin
                        freed_idx[freed_top] = AddrW'(idx);
                        freed_top++;
                    end
                    in_use--;
                end
            end
            KIND_RESET: clear_pool();
            default: ;  // unused kind leaves the pool alone
        endcase
        r.used = BytesW'(in_use << sh);
        r.peak = BytesW'(high_water << sh);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking, sampled mid cycle so edge ordering cannot matter
    // ------------------------------------------------------------------
    task automatic flag_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            flag_failure($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
        end
    endtask

    always @(negedge i_clk) begin
        t_pool_answer want;
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                if (answers_due.size() == 0) begin
                    flag_failure($sformatf("result with nothing owed: status %0d offset 0x%0h",
                                           o_status, o_chunk_offset));
                end else begin
                    want = answers_due.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("chunk_offset", 32'(want.offset), 32'(o_chunk_offset));
                    check_field("used_bytes", 32'(want.used), 32'(o_used_bytes));
                    check_field("peak_bytes", 32'(want.peak), 32'(o_peak_bytes));
                end
            end else if (o_valid !== 1'b0) begin
                flag_failure("o_valid is unknown");
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers; every task is entered and left at a rising edge
    // ------------------------------------------------------------------
    // every item draws a random wait before it is sent, weighted by the style
    function automatic int draw_gap();
        case (gap_style)
            0:       return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 17) : 0;
            1:       return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17)
                                                        : $urandom_range(0, 3);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    // send one item, wait for it to be taken, then log what it should produce
    task automatic send_item(input t_kind k, input logic [ReqW-1:0] req,
                             input logic [OffW-1:0] offs);
        int           gap;
        int           j;
        t_pool_answer answer;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_kind          <= k;
        i_request_bytes <= req;
        i_free_offset   <= offs;
        do @(negedge i_clk); while (busy !== 1'b0);
        @(posedge i_clk);
        // taken at this edge
        answer = pool_answer(k, req, offs);
        answers_due.push_back(answer);
        items_sent++;
        status_seen[int'(answer.status)]++;
        if (k == KIND_ALLOC && answer.status == ST_OK) begin
            alloc_count++;
            held.push_back(answer.offset);
        end else if (k == KIND_FREE && answer.status == ST_OK) begin
            free_count++;
            for (j = 0; j < held.size(); j++) begin
                if (held[j] == offs) begin
                    held.delete(j);
                    break;
                end
            end
        end else if (k == KIND_RESET) begin
            held.delete();
        end
    endtask

    // drop start and let every owed result come back before touching the pool
    task automatic wait_drained();
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // a register write also resets the pool
    task automatic write_register(input t_reg_idx which, input logic [CfgDataW-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (which == REG_CHUNK_SHIFT) begin
            cfg_shift = value[ShiftW-1:0];
        end else begin
            cfg_count = value;
        end
        clear_pool();
        held.delete();
        cfg_writes++;
    endtask

    // requested shift in the low bits, junk in the bits the register ignores
    function automatic logic [CfgDataW-1:0] shift_word(input int unsigned sh);
        logic [CfgDataW-1:0] w;
        w = CfgDataW'($urandom);
        w[ShiftW-1:0] = ShiftW'(sh);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // default pool: 256 chunks of 8 bytes
    task automatic test_basic_requests();
        gap_style = 1;
        send_item(KIND_ALLOC, 17'd8, 24'd0);            // top chunk first
        send_item(KIND_ALLOC, 17'd0, 24'hFFFFFF);       // size mismatch, zero size
        send_item(KIND_ALLOC, 17'h10000, 24'd0);        // size mismatch, largest size
        send_item(KIND_FREE, 17'h1FFFF, 24'd1);         // misaligned offset
        send_item(KIND_FREE, 17'd8, 24'd2048);          // first chunk past the region
        send_item(KIND_FREE, 17'd8, 24'hFFFFFF);        // largest offset
        send_item(KIND_FREE, 17'd8, 24'd2040);          // good free
        send_item(KIND_FREE, 17'd8, 24'd2040);          // nothing allocated
        send_item(KIND_ALLOC, 17'd8, 24'd0);            // reuse from the freed stack
        send_item(KIND_ALLOC, 17'd8, 24'd0);            // next untouched chunk
        send_item(KIND_FREE, 17'd8, 24'd2040);
        send_item(KIND_FREE, 17'd8, 24'd2040);          // double free is not caught
        send_item(KIND_ALLOC, 17'd8, 24'd0);            // same chunk handed out twice
        send_item(KIND_ALLOC, 17'd8, 24'd0);
        send_item(KIND_NONE, 17'h1FFFF, 24'hFFFFFF);    // unused kind reports current state
        send_item(KIND_RESET, 17'h1FFFF, 24'hABCDEF);   // everything free, peak cleared
    endtask

    // clamped register values and the smallest pool
    task automatic test_register_limits();
        gap_style = 2;
        write_register(REG_CHUNK_SHIFT, 9'h1E0);        // shift 0 acts as 3
        send_item(KIND_ALLOC, 17'd8, 24'd0);
        write_register(REG_CHUNK_SHIFT, 9'd31);         // acts as 16
        send_item(KIND_ALLOC, 17'h10000, 24'd0);
        send_item(KIND_ALLOC, 17'd8, 24'd0);
        write_register(REG_CHUNK_COUNT, 9'd0);          // acts as one chunk
        send_item(KIND_ALLOC, 17'h10000, 24'd0);
        send_item(KIND_ALLOC, 17'h10000, 24'd0);        // pool full
        send_item(KIND_ALLOC, 17'd0, 24'd0);            // size reported before full
        send_item(KIND_FREE, 17'd0, 24'h010000);        // chunk one is outside the pool
        send_item(KIND_FREE, 17'd0, 24'd0);
        send_item(KIND_FREE, 17'd0, 24'd0);             // nothing allocated
        write_register(REG_CHUNK_SHIFT, 9'd2);          // acts as 3
        write_register(REG_CHUNK_COUNT, 9'h1FF);        // acts as 256
        send_item(KIND_ALLOC, 17'd8, 24'd0);
        write_register(REG_CHUNK_COUNT, 9'd257);
        write_register(REG_CHUNK_SHIFT, 9'd17);         // acts as 16
        send_item(KIND_ALLOC, 17'h10000, 24'd0);
    endtask

    // take every chunk of a full size pool, overrun it, then hand all back
    task automatic test_fill_and_drain();
        int          n;
        int          j;
        int unsigned csize;
        write_register(REG_CHUNK_SHIFT, shift_word($urandom_range(3, 16)));
        write_register(REG_CHUNK_COUNT, ($urandom_range(0, 1) != 0) ? 9'd256 : 9'h1FF);
        csize = 32'd1 << live_shift();
        for (n = 0; n <= MaxChunks; n++) begin
            gap_style = (n / 64) % 3;
            send_item(KIND_ALLOC, ReqW'(csize), OffW'($urandom));
        end
        n = 0;
        while (held.size() > 0) begin
            gap_style = (n++ / 50) % 3;
            j = $urandom_range(0, held.size() - 1);
            send_item(KIND_FREE, ReqW'($urandom), held[j]);
        end
        send_item(KIND_FREE, ReqW'($urandom), '0);       // pool is empty again
    endtask

    // one random request, mostly well formed, leaning on allocate by weight
    task automatic random_request(input int alloc_weight);
        int              roll;
        int unsigned     sh;
        int unsigned     cnt;
        int unsigned     beyond;
        logic [OffW-1:0] offs;
        sh   = live_shift();
        cnt  = live_count();
        roll = $urandom_range(0, 99);
        if (roll < alloc_weight) begin
            send_item(KIND_ALLOC, ReqW'(32'd1 << sh), OffW'($urandom));
        end else if (roll < 88) begin
            // a chunk in use, or any chunk of the pool which may be a double free
            if (held.size() > 0 && $urandom_range(0, 5) != 0) begin
                offs = held[$urandom_range(0, held.size() - 1)];
            end else begin
                offs = OffW'($urandom_range(0, cnt - 1) << sh);
            end
            send_item(KIND_FREE, ReqW'($urandom), offs);
        end else if (roll < 92) begin
            send_item(KIND_ALLOC, ReqW'($urandom), OffW'($urandom));
        end else if (roll < 95) begin
            case ($urandom_range(0, 2))
                0: offs = OffW'($urandom);
                1: begin
                    beyond = cnt + $urandom_range(0, 3);
                    offs = ((beyond << sh) < (32'd1 << OffW)) ? OffW'(beyond << sh) : '1;
                end
                default: offs = OffW'(($urandom_range(0, cnt - 1) << sh)
                                      | $urandom_range(1, (32'd1 << sh) - 1));
            endcase
            send_item(KIND_FREE, ReqW'($urandom), offs);
        end else if (roll < 97) begin
            send_item(KIND_RESET, ReqW'($urandom), OffW'($urandom));
        end else begin
            send_item(KIND_NONE, ReqW'($urandom), OffW'($urandom));
        end
    endtask

    // phases of mixed traffic, each on a fresh random chunk count and at random a new shift
    task automatic test_mixed_traffic();
        int                  phase;
        int                  alloc_weight;
        logic [CfgDataW-1:0] count_word;
        for (phase = 0; phase < 11; phase++) begin
            gap_style = phase % 3;
            if ($urandom_range(0, 1) != 0) begin
                write_register(REG_CHUNK_SHIFT, shift_word(($urandom_range(0, 3) == 0)
                               ? $urandom_range(0, 31) : $urandom_range(3, 16)));
            end
            // mostly small pools so that they fill up and drain often
            case ($urandom_range(0, 9))
                0:       count_word = '0;
                1:       count_word = CfgDataW'($urandom);
                2:       count_word = 9'd256;
                default: count_word = CfgDataW'($urandom_range(1, 16));
            endcase
            write_register(REG_CHUNK_COUNT, count_word);
            alloc_weight = $urandom_range(30, 75);
            repeat (30) random_request(alloc_weight);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_shift  = ShiftReset;
        cfg_count  = CountReset;
        clear_pool();
        gap_style   = 0;
        mismatches  = 0;
        items_sent  = 0;
        alloc_count = 0;
        free_count  = 0;
        cfg_writes  = 0;
        foreach (status_seen[j]) status_seen[j] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_requests();
        test_register_limits();
        test_fill_and_drain();
        test_mixed_traffic();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (answers_due.size() != 0) flag_failure("results still owed at the end");

        $display("ran %0d requests: %0d chunks handed out, %0d returned, %0d register writes",
                 items_sent, alloc_count, free_count, cfg_writes);
        $display("error replies: pool full %0d, size %0d, bad offset %0d, nothing allocated %0d",
                 status_seen[ST_FULL], status_seen[ST_SIZE], status_seen[ST_OFFSET],
                 status_seen[ST_EMPTY]);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #(2_000_000);
        $display("timeout waiting for the block");
        $display("simulation failed");
        $finish;
    end

endmodule
